>>> design/arpt_pkg.sv
// Shared types and constants for the ARP host table with aging.
`timescale 1ns / 1ps
package arpt_pkg;

  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = 5;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_REFRESH = 3'd1;
  localparam logic [2:0] ACT_INSTALL = 3'd2;
  localparam logic [2:0] ACT_REMOVE  = 3'd3;
  localparam logic [2:0] ACT_ZERO_IP = 3'd4;
  localparam logic [2:0] ACT_NO_INTF = 3'd5;
  localparam logic [2:0] ACT_FULL    = 3'd6;

  localparam logic [1:0] KIND_ZERO = 2'd0;
  localparam logic [1:0] KIND_ARP  = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [7:0]  port;
    logic [11:0] intf;
    logic        found;
  } arpt_cmd_t;

endpackage

>>> design/arpt_front.sv
// Front stage: accepts requests, classifies them and forwards them to the queue.
`timescale 1ns / 1ps
module arpt_front
  import arpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [31:0] in_sender_ip,
  input  logic [47:0] in_sender_mac,
  input  logic [7:0]  in_rx_port,
  input  logic [11:0] in_intf_id,
  input  logic        in_intf_found,
  input  logic        q_full,
  output logic        q_push,
  output arpt_cmd_t   q_cmd
);

  logic      cmd_v_r;
  logic      cmd_v_nxt;
  arpt_cmd_t cmd_r;
  arpt_cmd_t cmd_nxt;
  logic      accept;

  assign q_push = cmd_v_r && !q_full;
  assign busy   = cmd_v_r && q_full;
  assign accept = start && !busy;
  assign q_cmd  = cmd_r;

  always_comb begin
    cmd_nxt   = cmd_r;
    cmd_v_nxt = cmd_v_r;
    if (q_push) begin
      cmd_v_nxt = 1'b0;
    end
    if (accept) begin
      cmd_v_nxt     = 1'b1;
      cmd_nxt.ip    = in_sender_ip;
      cmd_nxt.mac   = in_sender_mac;
      cmd_nxt.port  = in_rx_port;
      cmd_nxt.intf  = in_intf_id;
      cmd_nxt.found = in_intf_found;
      if (in_mode) begin
        cmd_nxt.kind = KIND_TICK;
      end else if (in_sender_ip == 32'd0) begin
        cmd_nxt.kind = KIND_ZERO;
      end else begin
        cmd_nxt.kind = KIND_ARP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_v_r <= 1'b0;
    end else begin
      cmd_v_r <= cmd_v_nxt;
    end
    cmd_r <= cmd_nxt;
  end

endmodule

>>> design/arpt_queue.sv
// Two-entry command queue between the front and back stages.
`timescale 1ns / 1ps
module arpt_queue
  import arpt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  arpt_cmd_t push_cmd,
  input  logic      pop,
  output logic      full,
  output logic      not_empty,
  output arpt_cmd_t head
);

  arpt_cmd_t  slot_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       do_pop;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign head      = slot_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (do_pop) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> design/arpt_back.sv
// Back stage: scans the host table one entry per cycle and emits results.
`timescale 1ns / 1ps
module arpt_back
  import arpt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] ttl_cfg,
  input  logic        q_not_empty,
  input  arpt_cmd_t   q_head,
  output logic        q_pop,
  output logic        out_valid,
  output logic [2:0]  out_action,
  output logic [31:0] out_route_ip,
  output logic [47:0] out_route_mac,
  output logic [7:0]  out_route_port,
  output logic [11:0] out_route_intf,
  output logic        out_last
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic [31:0] ip_mem  [TABLE_ENTRIES];
  logic [15:0] ttl_mem [TABLE_ENTRIES];

  logic                     state_r, state_nxt;
  arpt_cmd_t                cmd_r, cmd_nxt;
  logic [CNT_W-1:0]         scan_cnt_r, scan_cnt_nxt;
  logic                     chk_v_r;
  logic [IDX_W-1:0]         chk_idx_r;
  logic [31:0]              rd_ip_r;
  logic [15:0]              rd_ttl_r;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic                     free_v_r, free_v_nxt;
  logic [IDX_W-1:0]         free_idx_r, free_idx_nxt;
  logic [RES_CNT_W-1:0]     rm_cnt_r, rm_cnt_nxt;
  logic                     pend_v_r, pend_v_nxt;
  logic [31:0]              pend_ip_r, pend_ip_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_action_r, out_action_nxt;
  logic [31:0] out_ip_r, out_ip_nxt;
  logic [47:0] out_mac_r, out_mac_nxt;
  logic [7:0]  out_port_r, out_port_nxt;
  logic [11:0] out_intf_r, out_intf_nxt;
  logic        out_last_r, out_last_nxt;

  logic             scan_done;
  logic             rd_issue;
  logic [IDX_W-1:0] rd_addr;
  logic             chk_valid;
  logic [15:0]      ttl_dec;
  logic             wr_ip_en;
  logic             wr_ttl_en;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0]      wr_ip;
  logic [15:0]      wr_ttl;

  assign scan_done = scan_cnt_r == CNT_W'(TABLE_ENTRIES);
  assign rd_issue  = (state_r == ST_SCAN) && !scan_done;
  assign rd_addr   = scan_cnt_r[IDX_W-1:0];
  assign chk_valid = valid_r[chk_idx_r];
  assign ttl_dec   = (rd_ttl_r == 16'd0) ? 16'd0 : rd_ttl_r - 16'd1;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    scan_cnt_nxt   = scan_cnt_r;
    valid_nxt      = valid_r;
    free_v_nxt     = free_v_r;
    free_idx_nxt   = free_idx_r;
    rm_cnt_nxt     = rm_cnt_r;
    pend_v_nxt     = pend_v_r;
    pend_ip_nxt    = pend_ip_r;
    out_valid_nxt  = 1'b0;
    out_action_nxt = ACT_NONE;
    out_ip_nxt     = 32'd0;
    out_mac_nxt    = 48'd0;
    out_port_nxt   = 8'd0;
    out_intf_nxt   = 12'd0;
    out_last_nxt   = 1'b0;
    q_pop          = 1'b0;
    wr_ip_en       = 1'b0;
    wr_ttl_en      = 1'b0;
    wr_addr        = chk_idx_r;
    wr_ip          = cmd_r.ip;
    wr_ttl         = ttl_cfg;
    if (rd_issue) begin
      scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
    end
    case (state_r)
      ST_IDLE: begin
        if (q_not_empty) begin
          q_pop = 1'b1;
          if (q_head.kind == KIND_ZERO) begin
            out_valid_nxt  = 1'b1;
            out_action_nxt = ACT_ZERO_IP;
            out_last_nxt   = 1'b1;
          end else begin
            state_nxt    = ST_SCAN;
            cmd_nxt      = q_head;
            scan_cnt_nxt = '0;
            free_v_nxt   = 1'b0;
            rm_cnt_nxt   = '0;
            pend_v_nxt   = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (chk_v_r) begin
          if (cmd_r.kind == KIND_ARP) begin
            if (chk_valid && rd_ip_r == cmd_r.ip) begin
              wr_ttl_en      = 1'b1;
              out_valid_nxt  = 1'b1;
              out_action_nxt = ACT_REFRESH;
              out_ip_nxt     = cmd_r.ip;
              out_last_nxt   = 1'b1;
              state_nxt      = ST_IDLE;
            end else if (!chk_valid && !free_v_r) begin
              free_v_nxt   = 1'b1;
              free_idx_nxt = chk_idx_r;
            end
          end else if (chk_valid) begin
            wr_ttl_en = 1'b1;
            if (ttl_dec == 16'd0) begin
              if (rm_cnt_r < RES_CNT_W'(MAX_RESULTS)) begin
                wr_ttl_en            = 1'b0;
                valid_nxt[chk_idx_r] = 1'b0;
                rm_cnt_nxt           = rm_cnt_r + RES_CNT_W'(1);
                pend_v_nxt           = 1'b1;
                pend_ip_nxt          = rd_ip_r;
                if (pend_v_r) begin
                  out_valid_nxt  = 1'b1;
                  out_action_nxt = ACT_REMOVE;
                  out_ip_nxt     = pend_ip_r;
                end
              end else begin
                wr_ttl = 16'd1;
              end
            end else begin
              wr_ttl = ttl_dec;
            end
          end
        end else if (scan_done) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (cmd_r.kind == KIND_ARP) begin
            out_ip_nxt = cmd_r.ip;
            if (!cmd_r.found) begin
              out_action_nxt = ACT_NO_INTF;
            end else if (!free_v_r) begin
              out_action_nxt = ACT_FULL;
            end else begin
              valid_nxt[free_idx_r] = 1'b1;
              wr_ip_en              = 1'b1;
              wr_ttl_en             = 1'b1;
              wr_addr               = free_idx_r;
              out_action_nxt        = ACT_INSTALL;
              out_mac_nxt           = cmd_r.mac;
              out_port_nxt          = cmd_r.port;
              out_intf_nxt          = cmd_r.intf;
            end
          end else if (pend_v_r) begin
            out_action_nxt = ACT_REMOVE;
            out_ip_nxt     = pend_ip_r;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_ip_en) begin
      ip_mem[wr_addr] <= wr_ip;
    end
    if (wr_ttl_en) begin
      ttl_mem[wr_addr] <= wr_ttl;
    end
    rd_ip_r  <= ip_mem[rd_addr];
    rd_ttl_r <= ttl_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      chk_v_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      chk_v_r     <= rd_issue;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    scan_cnt_r   <= scan_cnt_nxt;
    chk_idx_r    <= rd_addr;
    free_v_r     <= free_v_nxt;
    free_idx_r   <= free_idx_nxt;
    rm_cnt_r     <= rm_cnt_nxt;
    pend_ip_r    <= pend_ip_nxt;
    out_action_r <= out_action_nxt;
    out_ip_r     <= out_ip_nxt;
    out_mac_r    <= out_mac_nxt;
    out_port_r   <= out_port_nxt;
    out_intf_r   <= out_intf_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_action     = out_action_r;
  assign out_route_ip   = out_ip_r;
  assign out_route_mac  = out_mac_r;
  assign out_route_port = out_port_r;
  assign out_route_intf = out_intf_r;
  assign out_last       = out_last_r;

endmodule

>>> design/arp_host_table_aging.sv
// Top level of the ARP host table with aging: config register, front, queue and back.
//
//   channel   direction  handshake             payload
//   request   in         start / busy          in_mode .. in_intf_found
//   result    out        out_valid (1 cycle)   out_action .. out_last
//   config    in         psel/penable/pready   ttl_seconds at byte address 0
//
// Zero-IP request: one result; the back stage pops it when idle and registers the result.
// ARP or tick request: the back stage reads one table entry per cycle through the single read
// port of the IP and lifetime memories; a refresh ends at the matching entry. The final result
// is registered and appears in the cycle after the back stage finishes.
// A tick emits at most one result per cycle; the last of them carries out_last.
// Two requests can wait in the queue and one in the front register; busy rises when all are full.
// Reset is synchronous and clears the valid bits at once; the receiver cannot stall.
`timescale 1ns / 1ps
module arp_host_table_aging
  import arpt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [31:0] in_sender_ip,
  input  logic [47:0] in_sender_mac,
  input  logic [7:0]  in_rx_port,
  input  logic [11:0] in_intf_id,
  input  logic        in_intf_found,
  output logic        out_valid,
  output logic [2:0]  out_action,
  output logic [31:0] out_route_ip,
  output logic [47:0] out_route_mac,
  output logic [7:0]  out_route_port,
  output logic [11:0] out_route_intf,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] ttl_seconds_r;
  logic [15:0] ttl_seconds_nxt;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_not_empty;
  arpt_cmd_t   push_cmd;
  arpt_cmd_t   head_cmd;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, ttl_seconds_r} : 32'd0;

  always_comb begin
    ttl_seconds_nxt = ttl_seconds_r;
    if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      ttl_seconds_nxt = pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_seconds_r <= 16'd300;
    end else begin
      ttl_seconds_r <= ttl_seconds_nxt;
    end
  end

  arpt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_sender_ip  (in_sender_ip),
    .in_sender_mac (in_sender_mac),
    .in_rx_port    (in_rx_port),
    .in_intf_id    (in_intf_id),
    .in_intf_found (in_intf_found),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  arpt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head_cmd)
  );

  arpt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .ttl_cfg        (ttl_seconds_r),
    .q_not_empty    (q_not_empty),
    .q_head         (head_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_action     (out_action),
    .out_route_ip   (out_route_ip),
    .out_route_mac  (out_route_mac),
    .out_route_port (out_route_port),
    .out_route_intf (out_route_intf),
    .out_last       (out_last)
  );

endmodule
